// ===== src/nbe_pkg.sv =====
// Shared constants, types and word functions of the node bitmap engine.
// No dependencies; the interfaces, datapath, controller, top and testbench import it.
package nbe_pkg;

    localparam int WORD_BITS     = 32;
    localparam int MAP_BITS_DEF  = 1024;
    localparam int NUM_MAPS_DEF  = 4;

    localparam int OP_W      = 4;
    localparam int MAP_IDX_W = 2;
    localparam int POS_W     = 10;
    localparam int NODE_W    = 11;
    localparam int VALUE_W   = 11;
    localparam int ACC_W     = 12;
    localparam int BIT_W     = 5;
    localparam int POPC_W    = 6;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-3:0] REG_NODE_COUNT = '0;
    localparam logic [NODE_W-1:0]     NODE_RESET     = 11'd1024;
    localparam logic [VALUE_W-1:0]    VALUE_MAX      = 11'h7FF;

    localparam logic [OP_W-1:0] OP_SET    = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 4'd2;
    localparam logic [OP_W-1:0] OP_AND    = 4'd3;
    localparam logic [OP_W-1:0] OP_OR     = 4'd4;
    localparam logic [OP_W-1:0] OP_COPY   = 4'd5;
    localparam logic [OP_W-1:0] OP_COUNT  = 4'd6;
    localparam logic [OP_W-1:0] OP_FILL   = 4'd7;
    localparam logic [OP_W-1:0] OP_SUBSET = 4'd8;

    typedef struct packed {
        logic load;
        logic sgl_rd;
        logic sgl_wr;
        logic walk_issue;
        logic fill_init;
        logic fill_write;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic op_single;
        logic op_walk;
        logic op_fill;
        logic pos_ok;
        logic walk_done;
        logic pipe_busy;
        logic found;
        logic fill_last;
    } sts_t;

    function automatic logic [POPC_W-1:0] popcount32(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] x;
        x = v;
        x = (x & 32'h55555555) + ((x >> 1)  & 32'h55555555);
        x = (x & 32'h33333333) + ((x >> 2)  & 32'h33333333);
        x = (x & 32'h0F0F0F0F) + ((x >> 4)  & 32'h0F0F0F0F);
        x = (x & 32'h00FF00FF) + ((x >> 8)  & 32'h00FF00FF);
        x = (x & 32'h0000FFFF) + ((x >> 16) & 32'h0000FFFF);
        return x[POPC_W-1:0];
    endfunction

    // Offset of the first set bit, MSB-first; word assumed nonzero.
    function automatic logic [BIT_W-1:0] lead_zeros(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] x;
        logic [BIT_W-1:0]     n;
        x = v;
        n = '0;
        if (x[31:16] == '0)
        begin
            n = n + 5'd16;
            x = x << 16;
        end
        if (x[31:24] == '0)
        begin
            n = n + 5'd8;
            x = x << 8;
        end
        if (x[31:28] == '0)
        begin
            n = n + 5'd4;
            x = x << 4;
        end
        if (x[31:30] == '0)
        begin
            n = n + 5'd2;
            x = x << 2;
        end
        if (!x[31])
        begin
            n = n + 5'd1;
        end
        return n;
    endfunction

    function automatic logic [BIT_W-1:0] trail_zeros(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] x;
        logic [BIT_W-1:0]     n;
        x = v;
        n = '0;
        if (x[15:0] == '0)
        begin
            n = n + 5'd16;
            x = x >> 16;
        end
        if (x[7:0] == '0)
        begin
            n = n + 5'd8;
            x = x >> 8;
        end
        if (x[3:0] == '0)
        begin
            n = n + 5'd4;
            x = x >> 4;
        end
        if (x[1:0] == '0)
        begin
            n = n + 5'd2;
            x = x >> 2;
        end
        if (!x[0])
        begin
            n = n + 5'd1;
        end
        return n;
    endfunction

endpackage

// ===== src/nbe_if.sv =====
// Item channels of the node bitmap engine: request and result.
// Depends on nbe_pkg for the field widths.
interface nbe_in_if;
    import nbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [MAP_IDX_W-1:0] map_a;
    logic [MAP_IDX_W-1:0] map_b;
    logic [POS_W-1:0]     position;
    modport source (output valid, operation, map_a, map_b, position, input ready);
    modport sink   (input valid, operation, map_a, map_b, position, output ready);
endinterface

interface nbe_out_if;
    import nbe_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               status;
    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== src/nbe_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module nbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ===== src/nbe_datapath.sv =====
// Datapath: item registers, word walk pipeline, accumulators and bitmap RAM.
// Depends on nbe_pkg and nbe_ram.
module nbe_datapath #(
    parameter int MAP_BITS = nbe_pkg::MAP_BITS_DEF,
    parameter int NUM_MAPS = nbe_pkg::NUM_MAPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nbe_pkg::cmd_t                   cmd,
    output nbe_pkg::sts_t                   sts,
    input  logic [nbe_pkg::NODE_W-1:0]      node_count,
    input  logic [nbe_pkg::OP_W-1:0]        operation,
    input  logic [nbe_pkg::MAP_IDX_W-1:0]   map_a,
    input  logic [nbe_pkg::MAP_IDX_W-1:0]   map_b,
    input  logic [nbe_pkg::POS_W-1:0]       position,
    output logic [nbe_pkg::VALUE_W-1:0]     value,
    output logic                            status
);
    import nbe_pkg::*;

    localparam int WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W  = $clog2(WORDS + 1);
    localparam int DEPTH  = NUM_MAPS * WORDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MIDX_W = $clog2(NUM_MAPS);

    function automatic logic [MIDX_W-1:0] wrap_map(input logic [MAP_IDX_W-1:0] m);
        int v;
        v = int'(m);
        if (v >= NUM_MAPS)
        begin
            v = v - NUM_MAPS;
        end
        return MIDX_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] word_addr(input logic [MIDX_W-1:0] m,
                                                    input logic [WIDX_W-1:0] w);
        return ADDR_W'(int'(m) * WORDS + int'(w));
    endfunction

    logic [OP_W-1:0]      op_reg;
    logic [MIDX_W-1:0]    amap_reg;
    logic [MIDX_W-1:0]    bmap_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     wcnt_reg;
    logic                 s1_vld_reg;
    logic [WIDX_W-1:0]    s1_word_reg;
    logic                 s2_vld_reg;
    logic [POPC_W-1:0]    pc_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic                 sub_reg;
    logic                 found_reg;
    logic [WIDX_W-1:0]    first_w_reg;
    logic [BIT_W-1:0]     first_b_reg;
    logic [WIDX_W-1:0]    last_w_reg;
    logic [BIT_W-1:0]     last_b_reg;
    logic                 bit_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 status_reg;
    logic [DEPTH-1:0]     vld_reg;
    logic                 vld_a_reg;
    logic                 vld_b_reg;

    logic                 is_single;
    logic                 is_logic;
    logic                 is_walk;
    logic                 pos_ok;
    logic [CNT_W-1:0]     nw;
    logic [31:0]          nw_full;
    logic [WIDX_W-1:0]    pos_word;
    logic [WIDX_W-1:0]    widx;
    logic [ADDR_W-1:0]    single_addr;
    logic [ADDR_W-1:0]    raddr_a;
    logic [ADDR_W-1:0]    raddr_b;
    logic [WORD_BITS-1:0] rdata_a;
    logic [WORD_BITS-1:0] rdata_b;
    logic [WORD_BITS-1:0] a_word;
    logic [WORD_BITS-1:0] b_word;
    logic [WORD_BITS-1:0] pos_mask;
    logic [WORD_BITS-1:0] fill_mask;
    logic [BIT_W-1:0]     lo;
    logic [BIT_W-1:0]     hi;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [VALUE_W-1:0]   value_next;

    assign is_single = (op_reg == OP_SET) || (op_reg == OP_CLEAR) || (op_reg == OP_TEST);
    assign is_logic  = (op_reg == OP_AND) || (op_reg == OP_OR) || (op_reg == OP_COPY);
    assign is_walk   = is_logic || (op_reg == OP_COUNT) || (op_reg == OP_FILL)
                       || (op_reg == OP_SUBSET);

    assign pos_ok   = (32'(pos_reg) < 32'(node_count)) && (32'(pos_reg) < MAP_BITS);
    assign nw_full  = (32'(node_count) + 32'd31) >> 5;
    assign nw       = (nw_full > WORDS) ? CNT_W'(WORDS) : CNT_W'(nw_full);
    assign pos_word = WIDX_W'(32'(pos_reg) >> 5);
    assign widx     = wcnt_reg[WIDX_W-1:0];
    assign pos_mask = 32'h80000000 >> pos_reg[BIT_W-1:0];

    assign single_addr = word_addr(amap_reg, pos_word);
    assign raddr_a     = cmd.sgl_rd ? single_addr : word_addr(amap_reg, widx);
    assign raddr_b     = word_addr(bmap_reg, widx);

    assign a_word = vld_a_reg ? rdata_a : '0;
    assign b_word = vld_b_reg ? rdata_b : '0;

    assign lo        = (widx == first_w_reg) ? first_b_reg : '0;
    assign hi        = (widx == last_w_reg) ? last_b_reg : 5'd31;
    assign fill_mask = (32'hFFFFFFFF >> lo) & ~(32'h7FFFFFFF >> hi);

    always_comb
    begin
        we    = 1'b0;
        waddr = single_addr;
        wdata = a_word;
        priority if (cmd.sgl_wr && (op_reg == OP_SET))
        begin
            we    = 1'b1;
            wdata = a_word | pos_mask;
        end
        else if (cmd.sgl_wr && (op_reg == OP_CLEAR))
        begin
            we    = 1'b1;
            wdata = a_word & ~pos_mask;
        end
        else if (s1_vld_reg && is_logic)
        begin
            we    = 1'b1;
            waddr = word_addr(amap_reg, s1_word_reg);
            if (op_reg == OP_AND)
            begin
                wdata = a_word & b_word;
            end
            else if (op_reg == OP_OR)
            begin
                wdata = a_word | b_word;
            end
            else
            begin
                wdata = b_word;
            end
        end
        else if (cmd.fill_write)
        begin
            we    = 1'b1;
            waddr = word_addr(amap_reg, widx);
            wdata = fill_mask;
        end
        else
        begin
            we = 1'b0;
        end
    end

    always_comb
    begin
        priority if (op_reg == OP_TEST)
        begin
            value_next = VALUE_W'(bit_reg);
        end
        else if (op_reg == OP_COUNT)
        begin
            value_next = (acc_reg > ACC_W'(VALUE_MAX)) ? VALUE_MAX : acc_reg[VALUE_W-1:0];
        end
        else if (op_reg == OP_SUBSET)
        begin
            value_next = VALUE_W'(sub_reg);
        end
        else
        begin
            value_next = '0;
        end
    end

    nbe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end
        else
        begin
            s1_vld_reg <= cmd.walk_issue;
            s2_vld_reg <= s1_vld_reg;
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            priority if (cmd.load)
            begin
                wcnt_reg <= '0;
            end
            else if (cmd.fill_init)
            begin
                wcnt_reg <= CNT_W'(first_w_reg);
            end
            else if (cmd.walk_issue || cmd.fill_write)
            begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
            else
            begin
                wcnt_reg <= wcnt_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vld_a_reg   <= vld_reg[raddr_a];
        vld_b_reg   <= vld_reg[raddr_b];
        s1_word_reg <= widx;
        pc_reg      <= popcount32(a_word);
        if (cmd.load)
        begin
            op_reg    <= operation;
            amap_reg  <= wrap_map(map_a);
            bmap_reg  <= wrap_map(map_b);
            pos_reg   <= position;
            acc_reg   <= '0;
            sub_reg   <= 1'b1;
            found_reg <= 1'b0;
            bit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.sgl_wr && (op_reg == OP_TEST))
            begin
                bit_reg <= |(a_word & pos_mask);
            end
            if (s2_vld_reg && (op_reg == OP_COUNT))
            begin
                acc_reg <= acc_reg + ACC_W'(pc_reg);
            end
            if (s1_vld_reg && (op_reg == OP_SUBSET) && ((a_word & ~b_word) != '0))
            begin
                sub_reg <= 1'b0;
            end
            if (s1_vld_reg && (op_reg == OP_FILL) && (a_word != '0))
            begin
                if (!found_reg)
                begin
                    first_w_reg <= s1_word_reg;
                    first_b_reg <= lead_zeros(a_word);
                end
                found_reg  <= 1'b1;
                last_w_reg <= s1_word_reg;
                last_b_reg <= ~trail_zeros(a_word);
            end
        end
        if (cmd.result_load)
        begin
            value_reg  <= value_next;
            status_reg <= is_single && !pos_ok;
        end
    end

    assign sts.op_single = is_single;
    assign sts.op_walk   = is_walk;
    assign sts.op_fill   = (op_reg == OP_FILL);
    assign sts.pos_ok    = pos_ok;
    assign sts.walk_done = (wcnt_reg == nw);
    assign sts.pipe_busy = s1_vld_reg || s2_vld_reg;
    assign sts.found     = found_reg;
    assign sts.fill_last = (widx == last_w_reg);

    assign value  = value_reg;
    assign status = status_reg;
endmodule

// ===== src/nbe_ctrl.sv =====
// Controller state machine: sequences one item through the datapath.
// Depends on nbe_pkg for command and status types.
module nbe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output nbe_pkg::cmd_t cmd,
    input  nbe_pkg::sts_t sts
);
    import nbe_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DISPATCH = 8'b0000_0010,
        ST_SGL_RD   = 8'b0000_0100,
        ST_SGL_WR   = 8'b0000_1000,
        ST_WALK     = 8'b0001_0000,
        ST_DRAIN    = 8'b0010_0000,
        ST_FILL     = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (sts.op_single && sts.pos_ok)
                begin
                    state_next = ST_SGL_RD;
                end
                else if (sts.op_walk)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SGL_RD:
            begin
                cmd.sgl_rd = 1'b1;
                state_next = ST_SGL_WR;
            end
            ST_SGL_WR:
            begin
                cmd.sgl_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.walk_issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    if (sts.op_fill && sts.found)
                    begin
                        cmd.fill_init = 1'b1;
                        state_next    = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_write = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an unread item");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted item not dispatched");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_issue |-> !sts.walk_done)
        else $error("word read issued past covered words");

    a_fill_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_write |-> (sts.found && !sts.pipe_busy))
        else $error("fill write without a completed find pass");
endmodule

// ===== src/node_bitmap_engine.sv =====
// Node bitmap engine: set, clear, test, logic, count, fill and subset on bitmaps.
// A new item is accepted only in the idle state, once the last result has been loaded.
// In-range set, clear and test read one word, and set and clear write it back.
// Out-of-range positions and unused codes go straight to the result. Whole-map
// operations walk the covered words; fill then rewrites its first to last set word.
// Reset clears every map at once through per-word valid bits and sets node_count to 1024.
module node_bitmap_engine #(
    parameter int MAP_BITS = nbe_pkg::MAP_BITS_DEF,
    parameter int NUM_MAPS = nbe_pkg::NUM_MAPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    nbe_in_if.sink                           in_ch,
    nbe_out_if.source                        out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nbe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nbe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nbe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import nbe_pkg::*;

    logic [NODE_W-1:0] nc_reg;
    logic [NODE_W-1:0] nc_next;
    logic              nc_sel;
    cmd_t              cmd;
    sts_t              sts;

    assign pready = 1'b1;
    assign nc_sel = (paddr[APB_ADDR_W-1:2] == REG_NODE_COUNT);

    always_comb
    begin
        if (psel && penable && pwrite && pready && nc_sel)
        begin
            nc_next = pwdata[NODE_W-1:0];
        end
        else
        begin
            nc_next = nc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= NODE_RESET;
        end
        else
        begin
            nc_reg <= nc_next;
        end
    end

    assign prdata = nc_sel ? APB_DATA_W'(nc_reg) : '0;

    nbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    nbe_datapath #(
        .MAP_BITS (MAP_BITS),
        .NUM_MAPS (NUM_MAPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .node_count (nc_reg),
        .operation  (in_ch.operation),
        .map_a      (in_ch.map_a),
        .map_b      (in_ch.map_b),
        .position   (in_ch.position),
        .value      (out_ch.value),
        .status     (out_ch.status)
    );
endmodule

// ===== tb/node_bitmap_engine_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of node_bitmap_engine: a directed table, then random items
// over several node counts and idle patterns, checked by a bitmap model or literals.
// Depends on nbe_pkg, the nbe_in_if and nbe_out_if interfaces and the engine RTL.
module node_bitmap_engine_tb;
    import nbe_pkg::*;

    localparam int WORDS = MAP_BITS_DEF / WORD_BITS;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 110;
    localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};
    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
    localparam logic ST_OK = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [MAP_IDX_W-1:0] ma;
        logic [MAP_IDX_W-1:0] mb;
        logic [POS_W-1:0]     pos;
        bit                   literal;
        logic [VALUE_W-1:0]   lit_value;
        logic                 lit_status;
    } step_row_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               status;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    nbe_in_if  req_ch();
    nbe_out_if rsp_ch();

    node_bitmap_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [WORD_BITS-1:0] node_maps [NUM_MAPS_DEF][WORDS];
    logic [NODE_W-1:0]    node_count;
    outcome_t             pending [$];
    step_row_t            script [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int range_errors = 0;
    int holds_done = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic outcome_t apply_op(input step_row_t s);
        outcome_t r;
        int limit;
        int nw;
        int total;
        int first;
        int last;
        bit found;
        limit = (node_count > MAP_BITS_DEF) ? MAP_BITS_DEF : int'(node_count);
        nw = (limit + WORD_BITS - 1) / WORD_BITS;
        r.value = '0;
        r.status = ST_OK;
        case (s.op)
            OP_SET, OP_CLEAR, OP_TEST:
            begin
                if (int'(s.pos) >= limit)
                    r.status = ST_RANGE;
                else if (s.op == OP_SET)
                    node_maps[s.ma][s.pos >> 5][31 - s.pos[4:0]] = 1'b1;
                else if (s.op == OP_CLEAR)
                    node_maps[s.ma][s.pos >> 5][31 - s.pos[4:0]] = 1'b0;
                else
                    r.value = VALUE_W'(node_maps[s.ma][s.pos >> 5][31 - s.pos[4:0]]);
            end
            OP_AND:
                for (int i = 0; i < nw; i++)
                    node_maps[s.ma][i] &= node_maps[s.mb][i];
            OP_OR:
                for (int i = 0; i < nw; i++)
                    node_maps[s.ma][i] |= node_maps[s.mb][i];
            OP_COPY:
                for (int i = 0; i < nw; i++)
                    node_maps[s.ma][i] = node_maps[s.mb][i];
            OP_COUNT:
            begin
                total = 0;
                for (int i = 0; i < nw; i++)
                    total += $countones(node_maps[s.ma][i]);
                r.value = (total > VALUE_MAX) ? VALUE_MAX : total[VALUE_W-1:0];
            end
            OP_FILL:
            begin
                found = 1'b0;
                first = 0;
                last = 0;
                for (int p = 0; p < nw * WORD_BITS; p++)
                begin
                    if (node_maps[s.ma][p / 32][31 - (p % 32)])
                    begin
                        if (!found)
                            first = p;
                        found = 1'b1;
                        last = p;
                    end
                end
                if (found)
                    for (int p = first + 1; p < last; p++)
                        node_maps[s.ma][p / 32][31 - (p % 32)] = 1'b1;
            end
            OP_SUBSET:
            begin
                r.value = VALUE_W'(1);
                for (int i = 0; i < nw; i++)
                    if ((node_maps[s.ma][i] & ~node_maps[s.mb][i]) != '0)
                        r.value = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input int ma, input int mb,
                           input int pos, input bit literal, input int value,
                           input logic status);
        step_row_t s;
        s.op = op;
        s.ma = ma[MAP_IDX_W-1:0];
        s.mb = mb[MAP_IDX_W-1:0];
        s.pos = pos[POS_W-1:0];
        s.literal = literal;
        s.lit_value = value[VALUE_W-1:0];
        s.lit_status = status;
        script.push_back(s);
    endtask

    // Entered right after a rising edge; returns at the edge that takes the item.
    task automatic offer(input step_row_t s);
        outcome_t predicted;
        outcome_t typed;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= s.op;
        req_ch.map_a     <= s.ma;
        req_ch.map_b     <= s.mb;
        req_ch.position  <= s.pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_op(s);
        typed.value = s.lit_value;
        typed.status = s.lit_status;
        pending.push_back(s.literal ? typed : predicted);
        items_sent++;
        if (predicted.status == ST_RANGE)
            range_errors++;
    endtask

    task automatic release_channel();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [NODE_W-1:0] n);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= ($urandom() & ~32'h7FF) | APB_DATA_W'(n);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        node_count = n;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin : result_side
        int hold_left;
        outcome_t want;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (pending.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result value=%0d status=%0b",
                                 $realtime, rsp_ch.value, rsp_ch.status);
                end
                else
                begin
                    want = pending.pop_front();
                    if (rsp_ch.value !== want.value || rsp_ch.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d: value exp %0d got %0d, ",
                                      "status exp %0b got %0b"},
                                     $realtime, results_seen, want.value, rsp_ch.value,
                                     want.status, rsp_ch.status);
                    end
                end
                // hold off long enough for the engine to back up its input
                if (results_seen == 200 || results_seen == 700)
                begin
                    hold_left = 400;
                    holds_done++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int phase_nodes [PHASES];
        int span;
        int sel;
        int waited;
        step_row_t s;

        req_ch.valid = 1'b0;
        req_ch.operation = OP_SET;
        req_ch.map_a = '0;
        req_ch.map_b = '0;
        req_ch.position = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int m = 0; m < NUM_MAPS_DEF; m++)
            for (int w = 0; w < WORDS; w++)
                node_maps[m][w] = '0;
        node_count = NODE_RESET;

        add_row(OP_TEST,   0, 0, 0,    1, 0,    ST_OK);
        add_row(OP_COUNT,  3, 0, 0,    1, 0,    ST_OK);
        add_row(OP_SUBSET, 0, 1, 0,    1, 1,    ST_OK);
        add_row(OP_FILL,   3, 0, 0,    1, 0,    ST_OK);
        add_row(OP_COUNT,  3, 0, 0,    1, 0,    ST_OK);
        add_row(OP_SET,    0, 0, 0,    1, 0,    ST_OK);
        add_row(OP_SET,    0, 0, 1023, 1, 0,    ST_OK);
        add_row(OP_TEST,   0, 0, 1023, 0, 0,    ST_OK);
        add_row(OP_COUNT,  0, 0, 0,    0, 0,    ST_OK);
        add_row(OP_SET,    0, 2, 31,   0, 0,    ST_OK);
        add_row(OP_SET,    0, 2, 32,   0, 0,    ST_OK);
        add_row(OP_FILL,   0, 0, 0,    0, 0,    ST_OK);
        add_row(OP_COUNT,  0, 0, 0,    1, 1024, ST_OK);
        add_row(OP_COPY,   1, 0, 0,    0, 0,    ST_OK);
        add_row(OP_CLEAR,  1, 0, 512,  0, 0,    ST_OK);
        add_row(OP_TEST,   1, 0, 512,  0, 0,    ST_OK);
        add_row(OP_SUBSET, 0, 1, 0,    0, 0,    ST_OK);
        add_row(OP_SUBSET, 1, 0, 0,    0, 0,    ST_OK);
        add_row(OP_AND,    0, 1, 0,    0, 0,    ST_OK);
        add_row(OP_OR,     2, 1, 0,    0, 0,    ST_OK);
        add_row(OP_COUNT,  2, 0, 0,    0, 0,    ST_OK);
        add_row(OP_CLEAR,  2, 3, 1023, 0, 0,    ST_OK);
        add_row(OP_TEST,   2, 3, 1023, 0, 0,    ST_OK);
        add_row(OP_SPARE_LO, 1, 2, 700, 1, 0,   ST_OK);
        add_row(OP_SPARE_HI, 3, 3, 1023, 1, 0,  ST_OK);

        phase_nodes = '{1024, 0, 1, 33, 2047, 32, 1023, 0, 64};
        phase_nodes[7] = $urandom_range(1024, 1);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        recv_idle_pct = 80;
        foreach (script[i])
            offer(script[i]);
        release_channel();
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_node_count(phase_nodes[ph][NODE_W-1:0]);
            @(posedge clk);
            send_idle_pct = (ph % 3 == 0) ? 25 : (ph % 3 == 1) ? 80 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 25 : 0;
            span = (node_count > MAP_BITS_DEF) ? MAP_BITS_DEF : int'(node_count);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(99);
                if (sel < 30)
                    s.op = OP_SET;
                else if (sel < 38)
                    s.op = OP_CLEAR;
                else if (sel < 52)
                    s.op = OP_TEST;
                else if (sel < 57)
                    s.op = OP_AND;
                else if (sel < 62)
                    s.op = OP_OR;
                else if (sel < 66)
                    s.op = OP_COPY;
                else if (sel < 76)
                    s.op = OP_COUNT;
                else if (sel < 82)
                    s.op = OP_FILL;
                else if (sel < 94)
                    s.op = OP_SUBSET;
                else
                    s.op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
                s.ma = MAP_IDX_W'($urandom_range(NUM_MAPS_DEF - 1));
                s.mb = MAP_IDX_W'($urandom_range(NUM_MAPS_DEF - 1));
                if (span > 0 && $urandom_range(3) != 0)
                    s.pos = POS_W'($urandom_range(span - 1));
                else
                    s.pos = POS_W'($urandom());
                s.literal = 1'b0;
                s.lit_value = '0;
                s.lit_status = ST_OK;
                offer(s);
                // pause the sender until the engine has emptied
                if (k == PHASE_ITEMS / 2)
                begin
                    release_channel();
                    drain();
                end
            end
            release_channel();
            drain();
        end

        waited = 0;
        while (pending.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
        mismatches += pending.size();

        $display("covered %0d items, %0d results, %0d node-count settings, %0d out-of-range",
                 items_sent, results_seen, PHASES + 1, range_errors);
        $display("positions and %0d long result hold-offs", holds_done);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== node_bitmap_engine.f =====
src/nbe_pkg.sv
src/nbe_if.sv
src/nbe_ram.sv
src/nbe_datapath.sv
src/nbe_ctrl.sv
src/node_bitmap_engine.sv
tb/node_bitmap_engine_tb.sv
